FILE: hw/rtl/halton_radical_inverse_top_defines.svh
// ----------------------------------------------------------------------------
// halton radical inverse assertion macros
// checks are compiled for simulation and left empty for synthesis
// ----------------------------------------------------------------------------
`ifndef HALTON_RADICAL_INVERSE_TOP_DEFINES_SVH
`define HALTON_RADICAL_INVERSE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define HRI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// trigger at one edge implies consequence at the next edge
`define HRI_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
// trigger implies consequence at the same edge
`define HRI_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);
`else
`define HRI_ASSERT_ALWAYS(label, cond, msg)
`define HRI_ASSERT_NEXT(label, trig, cons, msg)
`define HRI_ASSERT_SAME(label, trig, cons, msg)
`endif

`endif

FILE: hw/rtl/hri_pkg.sv
// ----------------------------------------------------------------------------
// hri_pkg
// types, widths and constant tables of the halton radical inverse block
// ----------------------------------------------------------------------------
package hri_pkg;

    localparam int BASE_W        = 6;
    localparam int SAMPLE_W      = 31;
    localparam int PRIME_W       = 9;
    localparam int RECIP_W       = 31;
    localparam int DEN_W         = 40;
    localparam int DIGIT_W       = 10;
    localparam int FRACTION_BITS = 32;
    localparam int FRAC_CNT_W    = $clog2(FRACTION_BITS);
    localparam int ROM_DEPTH     = 61;

    // numerator of the reciprocal table, 2^31
    localparam logic [31:0] RECIP_NUM = 32'h8000_0000;

    localparam logic [PRIME_W-1:0] PRIME_ROM [ROM_DEPTH] = '{
        9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,  9'd29,
        9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,  9'd61,  9'd67,  9'd71,
        9'd73,  9'd79,  9'd83,  9'd89,  9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113,
        9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
        9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229,
        9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269, 9'd271, 9'd277, 9'd281,
        9'd283
    };

    // floor(2^31 / p), same order as the prime table
    localparam logic [RECIP_W-1:0] RECIP_ROM [ROM_DEPTH] = '{
        31'(RECIP_NUM / 32'd2),   31'(RECIP_NUM / 32'd3),   31'(RECIP_NUM / 32'd5),
        31'(RECIP_NUM / 32'd7),   31'(RECIP_NUM / 32'd11),  31'(RECIP_NUM / 32'd13),
        31'(RECIP_NUM / 32'd17),  31'(RECIP_NUM / 32'd19),  31'(RECIP_NUM / 32'd23),
        31'(RECIP_NUM / 32'd29),  31'(RECIP_NUM / 32'd31),  31'(RECIP_NUM / 32'd37),
        31'(RECIP_NUM / 32'd41),  31'(RECIP_NUM / 32'd43),  31'(RECIP_NUM / 32'd47),
        31'(RECIP_NUM / 32'd53),  31'(RECIP_NUM / 32'd59),  31'(RECIP_NUM / 32'd61),
        31'(RECIP_NUM / 32'd67),  31'(RECIP_NUM / 32'd71),  31'(RECIP_NUM / 32'd73),
        31'(RECIP_NUM / 32'd79),  31'(RECIP_NUM / 32'd83),  31'(RECIP_NUM / 32'd89),
        31'(RECIP_NUM / 32'd97),  31'(RECIP_NUM / 32'd101), 31'(RECIP_NUM / 32'd103),
        31'(RECIP_NUM / 32'd107), 31'(RECIP_NUM / 32'd109), 31'(RECIP_NUM / 32'd113),
        31'(RECIP_NUM / 32'd127), 31'(RECIP_NUM / 32'd131), 31'(RECIP_NUM / 32'd137),
        31'(RECIP_NUM / 32'd139), 31'(RECIP_NUM / 32'd149), 31'(RECIP_NUM / 32'd151),
        31'(RECIP_NUM / 32'd157), 31'(RECIP_NUM / 32'd163), 31'(RECIP_NUM / 32'd167),
        31'(RECIP_NUM / 32'd173), 31'(RECIP_NUM / 32'd179), 31'(RECIP_NUM / 32'd181),
        31'(RECIP_NUM / 32'd191), 31'(RECIP_NUM / 32'd193), 31'(RECIP_NUM / 32'd197),
        31'(RECIP_NUM / 32'd199), 31'(RECIP_NUM / 32'd211), 31'(RECIP_NUM / 32'd223),
        31'(RECIP_NUM / 32'd227), 31'(RECIP_NUM / 32'd229), 31'(RECIP_NUM / 32'd233),
        31'(RECIP_NUM / 32'd239), 31'(RECIP_NUM / 32'd241), 31'(RECIP_NUM / 32'd251),
        31'(RECIP_NUM / 32'd257), 31'(RECIP_NUM / 32'd263), 31'(RECIP_NUM / 32'd269),
        31'(RECIP_NUM / 32'd271), 31'(RECIP_NUM / 32'd277), 31'(RECIP_NUM / 32'd281),
        31'(RECIP_NUM / 32'd283)
    };

    typedef struct packed {
        logic [BASE_W-1:0]   base_index;
        logic [SAMPLE_W-1:0] sample_index;
    } hri_in_t;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] fraction;
        logic                     bad_base;
    } hri_out_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic back;
        logic upd;
        logic frac_init;
        logic frac_step;
        logic out_load;
    } hri_cmd_t;

    typedef struct packed {
        logic bad;
        logic j_zero;
        logic frac_last;
    } hri_sts_t;

endpackage

FILE: hw/rtl/hri_datapath.sv
// ----------------------------------------------------------------------------
// hri_datapath
// digit extraction by reciprocal multiply, numerator and denominator
// accumulation, bit-serial fraction divider and result register
// ----------------------------------------------------------------------------
module hri_datapath
    import hri_pkg::*;
#(
    parameter int NUM_BASES = 61
)
(
    input  logic     clk,
    input  hri_in_t  sample,
    input  hri_cmd_t cmd,
    output hri_sts_t sts,
    output hri_out_t result
);

    logic [PRIME_W-1:0]       p_reg, p_next;
    logic [RECIP_W-1:0]       m_reg, m_next;
    logic [SAMPLE_W-1:0]      j_reg, j_next;
    logic [SAMPLE_W-1:0]      q_est_reg, q_est_next;
    logic [DEN_W-1:0]         qp_reg, qp_next;
    logic [DEN_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    logic [FRAC_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                     bad_reg, bad_next;
    hri_out_t                 result_reg, result_next;

    logic                      in_bad;
    logic [BASE_W-1:0]         rom_idx;
    logic [2*SAMPLE_W-1:0]     prod;
    logic [SAMPLE_W-1:0]       diff;
    logic [DIGIT_W-1:0]        r0;
    logic [DIGIT_W-1:0]        dig;
    logic [DIGIT_W-1:0]        mirrored;
    logic [SAMPLE_W-1:0]       q_fix;
    logic [DEN_W:0]            rem_sh;

    assign in_bad  = sample.base_index >= BASE_W'(NUM_BASES);
    assign rom_idx = in_bad ? '0 : sample.base_index;

    // q_est is floor(j/p) or one less
    assign prod = (2*SAMPLE_W)'(j_reg) * (2*SAMPLE_W)'(m_reg);

    // remainder before correction stays below 2p
    assign diff     = j_reg - qp_reg[SAMPLE_W-1:0];
    assign r0       = diff[DIGIT_W-1:0];
    assign dig      = (r0 >= DIGIT_W'(p_reg)) ? r0 - DIGIT_W'(p_reg) : r0;
    assign q_fix    = (r0 >= DIGIT_W'(p_reg)) ? q_est_reg + SAMPLE_W'(1) : q_est_reg;
    assign mirrored = (dig == '0) ? '0 : DIGIT_W'(p_reg) - dig;

    assign rem_sh = {rem_reg, 1'b0};

    always_comb
    begin
        p_next      = p_reg;
        m_next      = m_reg;
        j_next      = j_reg;
        q_est_next  = q_est_reg;
        qp_next     = qp_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        bad_next    = bad_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            p_next   = PRIME_ROM[rom_idx];
            m_next   = RECIP_ROM[rom_idx];
            j_next   = sample.sample_index;
            num_next = '0;
            den_next = DEN_W'(1);
            bad_next = in_bad;
        end
        if (cmd.mul)
        begin
            q_est_next = prod[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (cmd.back)
        begin
            qp_next = DEN_W'(q_est_reg) * DEN_W'(p_reg);
        end
        if (cmd.upd)
        begin
            j_next   = q_fix;
            num_next = num_reg * DEN_W'(p_reg) + DEN_W'(mirrored);
            den_next = den_reg * DEN_W'(p_reg);
        end
        if (cmd.frac_init)
        begin
            rem_next = num_reg;
            quo_next = '0;
            cnt_next = '0;
        end
        if (cmd.frac_step)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + FRAC_CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            result_next.fraction = bad_reg ? '0 : quo_reg;
            result_next.bad_base = bad_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        m_reg      <= m_next;
        j_reg      <= j_next;
        q_est_reg  <= q_est_next;
        qp_reg     <= qp_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        bad_reg    <= bad_next;
        result_reg <= result_next;
    end

    assign sts.bad       = bad_reg;
    assign sts.j_zero    = (j_reg == '0);
    assign sts.frac_last = (cnt_reg == FRAC_CNT_W'(FRACTION_BITS - 1));
    assign result        = result_reg;

endmodule

FILE: hw/rtl/hri_ctrl.sv
// ----------------------------------------------------------------------------
// hri_ctrl
// sequencer for digit extraction, fraction division and result handoff
// ----------------------------------------------------------------------------
module hri_ctrl
    import hri_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_stall,
    output logic     result_valid,
    input  logic     result_stall,
    input  hri_sts_t sts,
    output hri_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_BACK = 6'b000100,
        ST_UPD  = 6'b001000,
        ST_FRAC = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign sample_stall = (state_reg != ST_IDLE);
    assign out_free     = !valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.bad)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.j_zero)
                begin
                    cmd.frac_init = 1'b1;
                    state_next    = ST_FRAC;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_BACK;
                end
            end
            ST_BACK:
            begin
                cmd.back   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_MUL;
            end
            ST_FRAC:
            begin
                cmd.frac_step = 1'b1;
                if (sts.frac_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait until the result register is empty or draining
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

endmodule

FILE: hw/rtl/halton_radical_inverse_top.sv
// ----------------------------------------------------------------------------
// halton_radical_inverse_top
// one halton sample coordinate with reversed digits, as a q0.32 fraction
// ----------------------------------------------------------------------------
// usage:
//   a request on the sample channel (sample_valid, sample_stall, sample)
//   carries a base index and a sample index; the result channel
//   (result_valid, result_stall, result) returns one fraction per request.
//   the block works on one request at a time. each base-p digit passes
//   through the reciprocal multiply, back-multiply and update steps,
//   and the fraction divider then runs one quotient bit per cycle.
//   a sample index has at most 31 digits in base two. after the last digit
//   the divider fills the fraction, the result register loads it and the
//   sequencer returns to idle for the next request. a base index out of
//   the table skips both loops and returns bad_base with a zero fraction.
//   a finished result sits in an output register, so the next request is
//   accepted while it waits; a stalled receiver holds the result there and
//   only blocks the block once the next result is ready too.
//   reset clears only the sequencer and the output valid, not the datapath.
// ----------------------------------------------------------------------------
`include "halton_radical_inverse_top_defines.svh"

module halton_radical_inverse_top
    import hri_pkg::*;
#(
    parameter int NUM_BASES = 61
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_stall,
    input  hri_in_t  sample,
    output logic     result_valid,
    input  logic     result_stall,
    output hri_out_t result
);

    hri_cmd_t cmd;
    hri_sts_t sts;

    hri_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    hri_datapath #(
        .NUM_BASES (NUM_BASES)
    ) u_datapath (
        .clk    (clk),
        .sample (sample),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    `HRI_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "datapath commands overlap")
    `HRI_ASSERT_SAME(a_no_overwrite, cmd.out_load, !result_valid || !result_stall, "result lost")
    `HRI_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "not busy")
    `HRI_ASSERT_SAME(a_bad_zero, result_valid && result.bad_base, result.fraction == '0, "nonzero")

endmodule
